### hw/rtl/lkv_pkg.sv
// Package for the LRU key-value cache: sizes, field types and opcodes.
// Used by the channel interfaces and the top level; depends on nothing.
package lkv_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int AGE_W       = IDX_W;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [AGE_W-1:0]        age_t;
	typedef logic [CAP_W-1:0]        cap_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_SET = 1'b1
	} op_t;

endpackage

### hw/rtl/lkv_req_if.sv
// Request channel of the LRU key-value cache: opcode, key and value.
// Depends on lkv_pkg.
interface lkv_req_if;
	logic            valid;
	logic            ready;
	lkv_pkg::op_t    opcode;
	lkv_pkg::key_t   key;
	lkv_pkg::val_t   value;

	modport source (output valid, opcode, key, value, input ready);
	modport sink   (input valid, opcode, key, value, output ready);
endinterface

### hw/rtl/lkv_rsp_if.sv
// Response channel of the LRU key-value cache: found, read value, eviction.
// Depends on lkv_pkg.
interface lkv_rsp_if;
	logic            valid;
	logic            ready;
	logic            found;
	lkv_pkg::val_t   read_value;
	logic            evicted;

	modport source (output valid, found, read_value, evicted, input ready);
	modport sink   (input valid, found, read_value, evicted, output ready);
endinterface

### hw/rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkv_pkg, lkv_req_if and lkv_rsp_if.
//
// Channel  | Role   | Payload
// ---------+--------+-------------------------------------------
// req      | sink   | opcode, key, value
// rsp      | source | found, read_value, evicted
// cfg      | write  | cfg_wdata -> capacity, taken when cfg_we
//
// The key compare over the tag registers and the value memory access happen
// at the accepting edge; the read data is registered beside the lookup stage
// flags and then moves to the output register. A new request is taken
// once the previous one has left the lookup stage. A stalled response holds
// in the output register; one more transaction can finish behind it.
// Reset empties the cache at once (all entries invalid) and sets capacity to 16.
module lru_key_value_cache (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  lkv_pkg::cap_t        cfg_wdata,
	lkv_req_if.sink              req,
	lkv_rsp_if.source            rsp
);

	localparam int N = lkv_pkg::MAX_ENTRIES;

	// tag side state
	lkv_pkg::key_t  keys_q  [N];
	logic [N-1:0]   valid_q;
	lkv_pkg::age_t  age_q   [N];
	lkv_pkg::cnt_t  count_q;
	lkv_pkg::cap_t  cap_q;

	// value memory
	lkv_pkg::val_t  val_mem [N];
	lkv_pkg::val_t  rdata_q;

	// lookup stage
	logic           valid_s1;
	logic           set_s1;
	logic           found_s1;
	logic           evicted_s1;

	// output register
	logic           out_valid_q;
	logic           found_q;
	lkv_pkg::val_t  read_value_q;
	logic           evicted_q;

	logic           accept;
	logic           is_set;
	logic [N-1:0]   hit_vec;
	logic           hit;
	lkv_pkg::idx_t  hit_idx;
	lkv_pkg::idx_t  free_idx;
	lkv_pkg::idx_t  victim_idx;
	lkv_pkg::cnt_t  eff_cap;
	logic           has_room;
	lkv_pkg::idx_t  tgt_idx;
	lkv_pkg::cnt_t  old_age;
	logic           upd_state;
	logic           move_s1;
	lkv_pkg::cnt_t  oldest_age;

	assign accept  = req.valid && req.ready;
	assign is_set  = (req.opcode == lkv_pkg::OP_SET);
	assign req.ready = !valid_s1;
	assign move_s1 = valid_s1 && (!out_valid_q || rsp.ready);

	// Compare the key with every valid tag
	always_comb begin
		for (int i = 0; i < N; i++) begin
			hit_vec[i] = valid_q[i] && (keys_q[i] == req.key);
		end
	end
	assign hit = |hit_vec;

	// Pick the hit entry, first free entry and least recent entry
	assign oldest_age = count_q - lkv_pkg::cnt_t'(1);
	always_comb begin
		hit_idx    = '0;
		free_idx   = '0;
		victim_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = lkv_pkg::idx_t'(i);
			end
			if (!valid_q[i]) begin
				free_idx = lkv_pkg::idx_t'(i);
			end
			if (valid_q[i] && (lkv_pkg::cnt_t'(age_q[i]) == oldest_age)) begin
				victim_idx = lkv_pkg::idx_t'(i);
			end
		end
	end

	// Clamp capacity to 1 .. N
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lkv_pkg::cnt_t'(1);
		end else if (cap_q > lkv_pkg::cap_t'(N)) begin
			eff_cap = lkv_pkg::cnt_t'(N);
		end else begin
			eff_cap = lkv_pkg::cnt_t'(cap_q);
		end
	end
	assign has_room = (count_q < eff_cap);

	// Entry to touch and its age before the touch (N means older than all)
	always_comb begin
		if (hit) begin
			tgt_idx = hit_idx;
			old_age = lkv_pkg::cnt_t'(age_q[hit_idx]);
		end else if (has_room) begin
			tgt_idx = free_idx;
			old_age = lkv_pkg::cnt_t'(N);
		end else begin
			tgt_idx = victim_idx;
			old_age = lkv_pkg::cnt_t'(age_q[victim_idx]);
		end
	end
	assign upd_state = accept && (hit || is_set);

	// Update tags, valid bits, ages and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < N; i++) begin
				age_q[i] <= '0;
			end
		end else if (upd_state) begin
			for (int i = 0; i < N; i++) begin
				if (lkv_pkg::idx_t'(i) == tgt_idx) begin
					age_q[i] <= '0;
				end else if (valid_q[i] && (lkv_pkg::cnt_t'(age_q[i]) < old_age)) begin
					age_q[i] <= age_q[i] + lkv_pkg::age_t'(1);
				end
			end
			if (!hit && has_room) begin
				valid_q[free_idx] <= 1'b1;
				count_q <= count_q + lkv_pkg::cnt_t'(1);
			end
		end
	end

	// Store the key of an inserted entry
	always_ff @(posedge clk) begin
		if (accept && is_set && !hit) begin
			keys_q[tgt_idx] <= req.key;
		end
	end

	// Write the value on set, read it on get
	always_ff @(posedge clk) begin
		if (accept && is_set) begin
			val_mem[tgt_idx] <= req.value;
		end
		if (accept && !is_set) begin
			rdata_q <= val_mem[hit_idx];
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Lookup stage: hold flags until the read data is ready to leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1     <= is_set;
			found_s1   <= hit;
			evicted_s1 <= is_set && !hit && !has_room;
		end
	end

	// Output register: advance when empty or drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			found_q   <= found_s1;
			evicted_q <= evicted_s1;
			if (set_s1) begin
				read_value_q <= '0;
			end else if (found_s1) begin
				read_value_q <= rdata_q;
			end else begin
				read_value_q <= '1;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.found      = found_q;
	assign rsp.read_value = read_value_q;
	assign rsp.evicted    = evicted_q;

endmodule
